### src/lcpc_pkg.sv
package lcpc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int MAX_AVERAGE = 64;
    localparam int SUM_W       = 31;
    localparam int CNT_W       = 7;
    localparam int SCALE_W     = 16;
    localparam int WEIGHT_W    = 25;
    localparam int DIVISOR_W   = 24;
    localparam int Q_LONG      = 31;
    localparam int Q_SHORT     = 24;
    localparam int STEP_W      = 5;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 56;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_TARE   = 2'd1;
    localparam logic [1:0] CMD_REF    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARE_SAMPLES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_DIVISOR  = 2'd2;

    localparam logic [CNT_W-1:0]   WEIGHT_SAMPLES_RST = 7'd10;
    localparam logic [CNT_W-1:0]   TARE_SAMPLES_RST   = 7'd5;
    localparam logic [SCALE_W-1:0] SCALE_DIVISOR_RST  = 16'd440;

    typedef enum logic [1:0] {
        KIND_WEIGHT = 2'd0,
        KIND_TARE   = 2'd1,
        KIND_REF    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        OP_TARE_START,
        OP_REF_REQ,
        OP_AVG_TARE,
        OP_AVG_WEIGH
    } op_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_AVG,
        B_SCALE,
        B_COUNT,
        B_OUT
    } back_state_t;

    typedef struct packed {
        op_t              op;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] n;
    } job_t;

    typedef struct packed {
        logic                 start;
        logic                 short_op;
        logic [SUM_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [SUM_W-1:0]     quotient;
        logic [DIVISOR_W-1:0] remainder;
    } div_rsp_t;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] r;
        if (n == '0) begin
            r = CNT_W'(1);
        end else if (n > CNT_W'(MAX_AVERAGE)) begin
            r = CNT_W'(MAX_AVERAGE);
        end else begin
            r = n;
        end
        return r;
    endfunction

endpackage

### src/lcpc_fifo.sv
module lcpc_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  lcpc_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output lcpc_pkg::job_t  head_job,
    output logic            empty
);

    lcpc_pkg::job_t mem [lcpc_pkg::QUEUE_DEPTH];

    logic [lcpc_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [lcpc_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [lcpc_pkg::QPTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (lcpc_pkg::QPTR_W+1)'(lcpc_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### src/lcpc_front.sv
module lcpc_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lcpc_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]                      s_tuser,
    input  logic [lcpc_pkg::CNT_W-1:0]      weight_samples,
    input  logic [lcpc_pkg::CNT_W-1:0]      tare_samples,
    input  logic                            queue_full,
    output logic                            push,
    output lcpc_pkg::job_t                  push_job
);

    logic [lcpc_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [lcpc_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic                       tare_reg, tare_next;

    logic                           accept;
    logic [lcpc_pkg::SAMPLE_BITS-1:0] offset_word;
    logic [lcpc_pkg::SUM_W-1:0]     sum_add;
    logic [lcpc_pkg::CNT_W-1:0]     idx_inc;
    logic [lcpc_pkg::CNT_W-1:0]     n_cur;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    // two's complement to offset binary: flip the top bit
    assign offset_word = {~s_tdata[lcpc_pkg::SAMPLE_BITS-1],
                          s_tdata[lcpc_pkg::SAMPLE_BITS-2:0]};
    assign sum_add = sum_reg + lcpc_pkg::SUM_W'(offset_word);
    assign idx_inc = idx_reg + 1'b1;
    assign n_cur   = lcpc_pkg::clamp_count(tare_reg ? tare_samples : weight_samples);

    always_comb begin
        sum_next  = sum_reg;
        idx_next  = idx_reg;
        tare_next = tare_reg;
        push      = 1'b0;
        push_job  = '{op: lcpc_pkg::OP_AVG_WEIGH, sum: sum_add, n: n_cur};
        if (accept) begin
            case (s_tuser)
                lcpc_pkg::CMD_TARE: begin
                    tare_next   = 1'b1;
                    sum_next    = '0;
                    idx_next    = '0;
                    push        = 1'b1;
                    push_job.op = lcpc_pkg::OP_TARE_START;
                end
                lcpc_pkg::CMD_REF: begin
                    // ignored while a tare is running
                    if (!tare_reg) begin
                        push        = 1'b1;
                        push_job.op = lcpc_pkg::OP_REF_REQ;
                    end
                end
                lcpc_pkg::CMD_SAMPLE: begin
                    if (idx_inc >= n_cur) begin
                        push        = 1'b1;
                        push_job.op = tare_reg ? lcpc_pkg::OP_AVG_TARE
                                               : lcpc_pkg::OP_AVG_WEIGH;
                        sum_next    = '0;
                        idx_next    = '0;
                        tare_next   = 1'b0;
                    end else begin
                        sum_next = sum_add;
                        idx_next = idx_inc;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            idx_reg  <= '0;
            tare_reg <= 1'b0;
        end else begin
            sum_reg  <= sum_next;
            idx_reg  <= idx_next;
            tare_reg <= tare_next;
        end
    end

endmodule

### src/lcpc_div.sv
module lcpc_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  lcpc_pkg::div_req_t  req,
    output lcpc_pkg::div_rsp_t  rsp
);

    logic [lcpc_pkg::DIVISOR_W-1:0] rem_reg, rem_next;
    logic [lcpc_pkg::SUM_W-1:0]     quo_reg, quo_next;
    logic [lcpc_pkg::DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [lcpc_pkg::STEP_W-1:0]    step_reg, step_next;
    logic                           done_reg, done_next;

    logic [lcpc_pkg::DIVISOR_W:0]   shifted;
    logic [lcpc_pkg::DIVISOR_W+1:0] trial;
    logic                           fits;

    assign shifted = {rem_reg, quo_reg[lcpc_pkg::SUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = !trial[lcpc_pkg::DIVISOR_W+1];

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next = '0;
            dvs_next = req.divisor;
            if (req.short_op) begin
                // align a short dividend to the top so fewer steps are needed
                quo_next  = {req.dividend[lcpc_pkg::Q_SHORT-1:0],
                             {(lcpc_pkg::SUM_W-lcpc_pkg::Q_SHORT){1'b0}}};
                step_next = lcpc_pkg::STEP_W'(lcpc_pkg::Q_SHORT);
            end else begin
                quo_next  = req.dividend;
                step_next = lcpc_pkg::STEP_W'(lcpc_pkg::Q_LONG);
            end
        end else if (step_reg != '0) begin
            rem_next  = fits ? trial[lcpc_pkg::DIVISOR_W-1:0]
                             : shifted[lcpc_pkg::DIVISOR_W-1:0];
            quo_next  = {quo_reg[lcpc_pkg::SUM_W-2:0], fits};
            step_next = step_reg - 1'b1;
            done_next = (step_reg == lcpc_pkg::STEP_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp = '{done: done_reg, quotient: quo_reg, remainder: rem_reg};

endmodule

### src/lcpc_back.sv
module lcpc_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lcpc_pkg::job_t                  job,
    input  logic                            job_empty,
    output logic                            job_pop,
    input  logic [lcpc_pkg::SCALE_W-1:0]    scale_divisor,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lcpc_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]                      m_tuser
);

    localparam int WW = lcpc_pkg::WEIGHT_W;
    localparam int DW = lcpc_pkg::DIVISOR_W;

    lcpc_pkg::div_req_t div_req;
    lcpc_pkg::div_rsp_t div_rsp;

    lcpc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    lcpc_pkg::back_state_t state_reg, state_next;

    logic                       is_tare_reg, is_tare_next;
    logic                       neg_reg, neg_next;
    logic [WW-1:0]              w_reg, w_next;
    logic                       ref_pending_reg, ref_pending_next;
    logic [DW-1:0]              zero_offset_reg, zero_offset_next;
    logic [WW-1:0]              ref_weight_reg, ref_weight_next;
    logic                       ref_valid_reg, ref_valid_next;
    logic [WW-1:0]              last_event_reg, last_event_next;
    lcpc_pkg::kind_t            res_kind_reg, res_kind_next;
    logic [WW-1:0]              res_w_reg, res_w_next;
    logic [WW-1:0]              res_cnt_reg, res_cnt_next;
    logic                       res_valid_reg, res_valid_next;
    logic                       res_ev_reg, res_ev_next;
    logic                       m_valid_reg, m_valid_next;
    logic [lcpc_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [1:0]                 out_kind_reg, out_kind_next;

    // average and tared difference
    logic [DW-1:0]              avg;
    logic [WW-1:0]              diff;
    logic [WW-1:0]              diff_neg;
    logic [DW-1:0]              diff_mag;
    logic [lcpc_pkg::SCALE_W-1:0] scale_eff;
    // scaled weight
    logic [DW-1:0]              scale_q;
    logic [WW-1:0]              q25;
    logic [WW-1:0]              w_new;
    logic                       store_ref;
    logic [WW-1:0]              ref_neg;
    logic [DW-1:0]              ref_abs;
    // piece count and change event
    logic [WW-1:0]              qc;
    logic [WW-1:0]              qs;
    logic [WW-1:0]              rc;
    logic [WW-1:0]              rs;
    logic                       round_up;
    logic [WW-1:0]              cnt;
    logic [WW:0]                d;
    logic [WW:0]                d_abs;
    logic                       ev;

    assign avg       = div_rsp.quotient[DW-1:0];
    assign diff      = {1'b0, avg} - {1'b0, zero_offset_reg};
    assign diff_neg  = -diff;
    assign diff_mag  = diff[WW-1] ? diff_neg[DW-1:0] : diff[DW-1:0];
    assign scale_eff = (scale_divisor == '0) ? lcpc_pkg::SCALE_W'(1) : scale_divisor;

    assign scale_q   = div_rsp.quotient[DW-1:0];
    assign q25       = {1'b0, scale_q};
    assign w_new     = neg_reg ? -q25 : q25;
    assign store_ref = ref_pending_reg && (scale_q != '0);
    assign ref_neg   = -ref_weight_reg;
    assign ref_abs   = ref_weight_reg[WW-1] ? ref_neg[DW-1:0] : ref_weight_reg[DW-1:0];

    // truncating signed division: quotient sign from both, remainder from dividend
    assign qc       = {1'b0, div_rsp.quotient[DW-1:0]};
    assign qs       = (w_reg[WW-1] ^ ref_weight_reg[WW-1]) ? -qc : qc;
    assign rc       = {1'b0, div_rsp.remainder};
    assign rs       = w_reg[WW-1] ? -rc : rc;
    assign round_up = $signed({rs, 1'b0}) >= $signed({ref_weight_reg[WW-1], ref_weight_reg});
    assign cnt      = qs + WW'(round_up);
    assign d        = {w_reg[WW-1], w_reg} - {last_event_reg[WW-1], last_event_reg};
    assign d_abs    = d[WW] ? -d : d;
    assign ev       = $signed({1'b0, d_abs, 1'b0})
                      >= $signed({{3{ref_weight_reg[WW-1]}}, ref_weight_reg});

    always_comb begin
        state_next       = state_reg;
        is_tare_next     = is_tare_reg;
        neg_next         = neg_reg;
        w_next           = w_reg;
        ref_pending_next = ref_pending_reg;
        zero_offset_next = zero_offset_reg;
        ref_weight_next  = ref_weight_reg;
        ref_valid_next   = ref_valid_reg;
        last_event_next  = last_event_reg;
        res_kind_next    = res_kind_reg;
        res_w_next       = res_w_reg;
        res_cnt_next     = res_cnt_reg;
        res_valid_next   = res_valid_reg;
        res_ev_next      = res_ev_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        out_data_next    = out_data_reg;
        out_kind_next    = out_kind_reg;
        job_pop          = 1'b0;
        div_req          = '0;

        case (state_reg)
            lcpc_pkg::B_IDLE: begin
                if (!job_empty) begin
                    job_pop = 1'b1;
                    case (job.op)
                        lcpc_pkg::OP_TARE_START: ref_pending_next = 1'b0;
                        lcpc_pkg::OP_REF_REQ:    ref_pending_next = 1'b1;
                        lcpc_pkg::OP_AVG_TARE, lcpc_pkg::OP_AVG_WEIGH: begin
                            div_req.start    = 1'b1;
                            div_req.short_op = 1'b0;
                            div_req.dividend = job.sum;
                            div_req.divisor  = DW'(job.n);
                            is_tare_next     = (job.op == lcpc_pkg::OP_AVG_TARE);
                            state_next       = lcpc_pkg::B_AVG;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lcpc_pkg::B_AVG: begin
                if (div_rsp.done) begin
                    if (is_tare_reg) begin
                        zero_offset_next = avg;
                        res_kind_next    = lcpc_pkg::KIND_TARE;
                        res_w_next       = '0;
                        res_cnt_next     = '0;
                        res_valid_next   = 1'b0;
                        res_ev_next      = 1'b0;
                        state_next       = lcpc_pkg::B_OUT;
                    end else begin
                        neg_next         = diff[WW-1];
                        div_req.start    = 1'b1;
                        div_req.short_op = 1'b1;
                        div_req.dividend = lcpc_pkg::SUM_W'(diff_mag);
                        div_req.divisor  = DW'(scale_eff);
                        state_next       = lcpc_pkg::B_SCALE;
                    end
                end
            end
            lcpc_pkg::B_SCALE: begin
                if (div_rsp.done) begin
                    w_next        = w_new;
                    res_kind_next = lcpc_pkg::KIND_WEIGHT;
                    if (store_ref) begin
                        ref_weight_next  = w_new;
                        ref_valid_next   = 1'b1;
                        ref_pending_next = 1'b0;
                        res_kind_next    = lcpc_pkg::KIND_REF;
                    end
                    if (ref_valid_reg || store_ref) begin
                        div_req.start    = 1'b1;
                        div_req.short_op = 1'b1;
                        div_req.dividend = lcpc_pkg::SUM_W'(scale_q);
                        div_req.divisor  = store_ref ? scale_q : ref_abs;
                        state_next       = lcpc_pkg::B_COUNT;
                    end else begin
                        res_w_next     = w_new;
                        res_cnt_next   = '0;
                        res_valid_next = 1'b0;
                        res_ev_next    = 1'b0;
                        state_next     = lcpc_pkg::B_OUT;
                    end
                end
            end
            lcpc_pkg::B_COUNT: begin
                if (div_rsp.done) begin
                    res_w_next     = w_reg;
                    res_cnt_next   = cnt;
                    res_valid_next = 1'b1;
                    res_ev_next    = ev;
                    if (ev) begin
                        last_event_next = w_reg;
                    end
                    state_next = lcpc_pkg::B_OUT;
                end
            end
            lcpc_pkg::B_OUT: begin
                // load the output register once it is free or being drained
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    out_kind_next = res_kind_reg;
                    out_data_next = {4'b0000, res_ev_reg, res_valid_reg,
                                     res_cnt_reg, res_w_reg};
                    state_next    = lcpc_pkg::B_IDLE;
                end
            end
            default: state_next = lcpc_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= lcpc_pkg::B_IDLE;
            ref_pending_reg <= 1'b0;
            zero_offset_reg <= '0;
            ref_weight_reg  <= '0;
            ref_valid_reg   <= 1'b0;
            last_event_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            ref_pending_reg <= ref_pending_next;
            zero_offset_reg <= zero_offset_next;
            ref_weight_reg  <= ref_weight_next;
            ref_valid_reg   <= ref_valid_next;
            last_event_reg  <= last_event_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        is_tare_reg   <= is_tare_next;
        neg_reg       <= neg_next;
        w_reg         <= w_next;
        res_kind_reg  <= res_kind_next;
        res_w_reg     <= res_w_next;
        res_cnt_reg   <= res_cnt_next;
        res_valid_reg <= res_valid_next;
        res_ev_reg    <= res_ev_next;
        out_data_reg  <= out_data_next;
        out_kind_reg  <= out_kind_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

endmodule

### src/load_cell_piece_counter.sv
// Path: each average passes through the shared divider: 31 steps for the average, then, for a
// weight, 24 steps for the scaling and 24 for the piece count once a reference is held or stored.
// Throughput: one input transaction per cycle while the two-entry job queue has room; jobs are
// served one at a time by the one-bit-per-cycle shared divider, each after the last result is in the output register.
// Reset (aresetn low, synchronous): sums, phase, offset, reference, queue and output are cleared;
// registers return to weight_samples 10, tare_samples 5, scale_divisor 440.
module load_cell_piece_counter (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lcpc_pkg::IN_DATA_W-1:0]      s_tdata,   // [23:0] raw_word
    input  logic [1:0]                          s_tuser,   // [1:0] cmd
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [24:0] weight, [49:25] piece_count, [50] count_valid, [51] change_event, [55:52] zero
    output logic [lcpc_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [1:0]                          m_tuser,   // [1:0] kind
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lcpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lcpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [lcpc_pkg::CNT_W-1:0]   weight_samples_reg, weight_samples_next;
    logic [lcpc_pkg::CNT_W-1:0]   tare_samples_reg, tare_samples_next;
    logic [lcpc_pkg::SCALE_W-1:0] scale_divisor_reg, scale_divisor_next;

    logic           queue_full;
    logic           queue_empty;
    logic           push;
    logic           pop;
    lcpc_pkg::job_t push_job;
    lcpc_pkg::job_t head_job;

    assign cfg_ready = 1'b1;

    always_comb begin
        weight_samples_next = weight_samples_reg;
        tare_samples_next   = tare_samples_reg;
        scale_divisor_next  = scale_divisor_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lcpc_pkg::REG_WEIGHT_SAMPLES: weight_samples_next = cfg_data[lcpc_pkg::CNT_W-1:0];
                lcpc_pkg::REG_TARE_SAMPLES:   tare_samples_next   = cfg_data[lcpc_pkg::CNT_W-1:0];
                lcpc_pkg::REG_SCALE_DIVISOR:  scale_divisor_next  = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_samples_reg <= lcpc_pkg::WEIGHT_SAMPLES_RST;
            tare_samples_reg   <= lcpc_pkg::TARE_SAMPLES_RST;
            scale_divisor_reg  <= lcpc_pkg::SCALE_DIVISOR_RST;
        end else begin
            weight_samples_reg <= weight_samples_next;
            tare_samples_reg   <= tare_samples_next;
            scale_divisor_reg  <= scale_divisor_next;
        end
    end

    lcpc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .weight_samples (weight_samples_reg),
        .tare_samples   (tare_samples_reg),
        .queue_full     (queue_full),
        .push           (push),
        .push_job       (push_job)
    );

    lcpc_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (queue_empty)
    );

    lcpc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job           (head_job),
        .job_empty     (queue_empty),
        .job_pop       (pop),
        .scale_divisor (scale_divisor_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule

### src/lcpc_checker.sv
module lcpc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [lcpc_pkg::IN_DATA_W-1:0]   s_tdata,
    input logic [1:0]                       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [lcpc_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [1:0]                       m_tuser,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [lcpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [lcpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // a tare result carries no weight, count or event
    a_tare_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == lcpc_pkg::KIND_TARE)) |-> (m_tdata[51:0] == '0))
        else $error("tare result with nonzero payload");

    // without a reference there is no count and no event
    a_no_ref_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[50]) |-> (m_tdata[49:25] == '0 && !m_tdata[51]))
        else $error("count or event without a stored reference");

    // a reference-stored result always has count_valid and a nonzero weight
    a_ref_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == lcpc_pkg::KIND_REF)) |-> (m_tdata[50] && m_tdata[24:0] != '0))
        else $error("reference result without valid nonzero weight");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind load_cell_piece_counter lcpc_checker u_lcpc_checker (.*);

### dv/load_cell_piece_counter_tb.sv
module load_cell_piece_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcpc_pkg::*;

    localparam logic [1:0]           CMD_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 2'd3;
    localparam int                   MAX_GAP       = 9;
    localparam int                   SETTLE_CYCLES = 120;
    localparam int                   RANDOM_ITEMS  = 600;
    localparam int                   PHASE_ITEMS   = 50;
    localparam int                   PRINT_LIMIT   = 100;

    typedef enum logic [1:0] {
        PH_WEIGH,
        PH_TARE,
        PH_REF_WAIT
    } scale_phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [24:0] weight;
        logic [24:0] pieces;
        logic        counted;
        logic        moved;
    } reading_t;

    typedef struct packed {
        logic        is_write;
        logic [1:0]  code;
        logic [23:0] value;
        logic        typed;
        reading_t    want;
    } step_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [1:0]            s_tuser   = CMD_SAMPLE;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_WEIGHT_SAMPLES;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // scale state as the block should hold it
    logic [6:0]   ws_reg   = WEIGHT_SAMPLES_RST;
    logic [6:0]   ts_reg   = TARE_SAMPLES_RST;
    logic [15:0]  div_reg  = SCALE_DIVISOR_RST;
    longint       acc_sum  = 0;
    int           acc_cnt  = 0;
    scale_phase_t ph       = PH_WEIGH;
    longint       zero_off = 0;
    longint       ref_wt   = 0;
    bit           ref_ok   = 1'b0;
    longint       last_ev  = 0;

    reading_t    expected_readings[$];
    reading_t    no_reading = '0;
    int          mismatch_count = 0;
    int          items_done = 0;
    bit          gaps_on = 1'b1;
    int unsigned ready_hold = 0;

    load_cell_piece_counter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic step_row_t in_row(logic [1:0] code, logic [23:0] value);
        step_row_t r;
        r = '0;
        r.code = code;
        r.value = value;
        return r;
    endfunction

    function automatic step_row_t typed_row(logic [1:0] code, logic [23:0] value,
                                            kind_t kind, int weight);
        step_row_t r;
        r = in_row(code, value);
        r.typed = 1'b1;
        r.want.kind = kind;
        r.want.weight = 25'(weight);
        return r;
    endfunction

    function automatic step_row_t wr_row(logic [1:0] idx, logic [15:0] value);
        step_row_t r;
        r = in_row(idx, 24'(value));
        r.is_write = 1'b1;
        return r;
    endfunction

    // converter word for a load of k pieces on top of base, both in offset binary
    function automatic logic [23:0] scale_word(longint base, longint unit, int k, longint nz);
        longint v;
        v = base + unit * k + longint'($urandom_range(0, 32'(2 * nz))) - nz;
        return v[23:0] ^ 24'h800000;
    endfunction

    task automatic flag_mismatch(string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [24:0] got, logic [24:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s got 0x%07h expected 0x%07h", name, got, want));
        end
    endtask

    // advance the scale state by one input transaction
    task automatic scale_step(input logic [1:0] cmd, input logic [23:0] raw,
                              output bit got, output reading_t rd);
        longint n, avg, w, cnt, d;
        got = 1'b0;
        rd = '0;
        if (cmd == CMD_TARE) begin
            ph = PH_TARE;
            acc_sum = 0;
            acc_cnt = 0;
        end else if (cmd == CMD_REF) begin
            if (ph == PH_WEIGH) ph = PH_REF_WAIT;
        end else if (cmd == CMD_SAMPLE) begin
            acc_sum = acc_sum + longint'(raw ^ 24'h800000);
            acc_cnt++;
            n = (ph == PH_TARE) ? ts_reg : ws_reg;
            if (n == 0) n = 1;
            else if (n > MAX_AVERAGE) n = MAX_AVERAGE;
            if (acc_cnt >= n) begin
                avg = acc_sum / n;
                acc_sum = 0;
                acc_cnt = 0;
                got = 1'b1;
                if (ph == PH_TARE) begin
                    zero_off = avg;
                    ph = PH_WEIGH;
                    rd.kind = KIND_TARE;
                end else begin
                    d = div_reg;
                    if (d == 0) d = 1;
                    w = (avg - zero_off) / d;
                    if (ph == PH_REF_WAIT && w != 0) begin
                        ref_wt = w;
                        ref_ok = 1'b1;
                        ph = PH_WEIGH;
                        rd.kind = KIND_REF;
                    end
                    cnt = 0;
                    if (ref_ok && ref_wt != 0) begin
                        cnt = w / ref_wt;
                        // round half up on the truncated remainder
                        if (2 * (w % ref_wt) >= ref_wt) cnt++;
                        d = w - last_ev;
                        if (d < 0) d = -d;
                        if (2 * d >= ref_wt) begin
                            rd.moved = 1'b1;
                            last_ev = w;
                        end
                    end
                    rd.weight = w[24:0];
                    rd.pieces = cnt[24:0];
                    rd.counted = ref_ok;
                end
            end
        end
    endtask

    task automatic send_item(logic [1:0] cmd, logic [23:0] raw, bit typed, reading_t want);
        int gap;
        bit got;
        reading_t rd;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= raw;
        do @(posedge aclk); while (!s_tready);
        scale_step(cmd, raw, got, rd);
        if (typed) expected_readings.push_back(want);
        else if (got) expected_readings.push_back(rd);
        if (cmd != CMD_UNUSED) items_done++;
    endtask

    // drop valid and hold until every expected result is out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_readings.size() != 0);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WEIGHT_SAMPLES: ws_reg = value[6:0];
            REG_TARE_SAMPLES:   ts_reg = value[6:0];
            REG_SCALE_DIVISOR:  div_reg = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin : rx_pace
        int unsigned h;
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_hold <= 0;
        end else if (m_tvalid && m_tready) begin
            h = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            m_tready <= (h == 0);
            ready_hold <= h;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            if (ready_hold == 1) m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : rx_check
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_readings.size() == 0) begin
                flag_mismatch("result transaction with nothing expected");
            end else begin
                want = expected_readings.pop_front();
                check_field("kind", 25'(m_tuser), 25'(want.kind));
                check_field("weight", m_tdata[24:0], want.weight);
                check_field("piece_count", m_tdata[49:25], want.pieces);
                check_field("count_valid", 25'(m_tdata[50]), 25'(want.counted));
                check_field("change_event", 25'(m_tdata[51]), 25'(want.moved));
            end
        end
    end

    initial begin : stimulus
        step_row_t rows[$];
        int        phase_no;
        int        r;
        int        k;
        int        n_words;
        logic [15:0] wsv, tsv, dv, junk;
        longint    eff_d, base, unit, nz;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // tare at the reset setting of five words, then the extremes at unit scale
        rows.push_back(in_row(CMD_TARE, 24'h000000));
        repeat (4) rows.push_back(in_row(CMD_SAMPLE, 24'h000000));
        rows.push_back(typed_row(CMD_SAMPLE, 24'h000000, KIND_TARE, 0));
        rows.push_back(wr_row(REG_WEIGHT_SAMPLES, 16'd1));
        rows.push_back(wr_row(REG_TARE_SAMPLES, 16'd1));
        rows.push_back(wr_row(REG_SCALE_DIVISOR, 16'd1));
        rows.push_back(typed_row(CMD_SAMPLE, 24'h7FFFFF, KIND_WEIGHT, 8388607));
        rows.push_back(typed_row(CMD_SAMPLE, 24'h800000, KIND_WEIGHT, -8388608));
        rows.push_back(in_row(CMD_TARE, 24'hFFFFFF));
        rows.push_back(typed_row(CMD_SAMPLE, 24'h7FFFFF, KIND_TARE, 0));
        rows.push_back(typed_row(CMD_SAMPLE, 24'h800000, KIND_WEIGHT, -16777215));
        rows.push_back(in_row(CMD_UNUSED, 24'hA5A5A5));
        // zero weight keeps the reference request pending, then a negative one is stored
        rows.push_back(in_row(CMD_REF, 24'h000000));
        rows.push_back(typed_row(CMD_SAMPLE, 24'h7FFFFF, KIND_WEIGHT, 0));
        rows.push_back(in_row(CMD_SAMPLE, 24'h800000));
        // reference request during a tare is dropped
        rows.push_back(in_row(CMD_TARE, 24'h000000));
        rows.push_back(in_row(CMD_REF, 24'h000000));
        rows.push_back(typed_row(CMD_SAMPLE, 24'h000000, KIND_TARE, 0));
        // a tare cancels a pending reference request
        rows.push_back(in_row(CMD_REF, 24'h000000));
        rows.push_back(in_row(CMD_TARE, 24'h000000));
        rows.push_back(typed_row(CMD_SAMPLE, 24'h000000, KIND_TARE, 0));
        rows.push_back(in_row(CMD_REF, 24'h000000));
        rows.push_back(in_row(CMD_SAMPLE, 24'h000064));
        rows.push_back(in_row(CMD_SAMPLE, 24'h0000FA));
        rows.push_back(in_row(CMD_SAMPLE, 24'hFFFF9C));
        rows.push_back(in_row(CMD_TARE, 24'h000000));
        rows.push_back(typed_row(CMD_SAMPLE, 24'h800000, KIND_TARE, 0));
        rows.push_back(in_row(CMD_SAMPLE, 24'h7FFFFF));

        foreach (rows[i]) begin
            if (rows[i].is_write) begin
                settle();
                write_reg(rows[i].code, rows[i].value[15:0]);
            end else begin
                send_item(rows[i].code, rows[i].value, rows[i].typed, rows[i].want);
            end
        end

        items_done = 0;
        phase_no = 0;
        while (items_done < RANDOM_ITEMS) begin
            settle();
            junk = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 511)) << 7 : 16'd0;
            case (phase_no)
                0: begin wsv = 16'd0;   tsv = 16'd0;   dv = 16'd0;     end
                1: begin wsv = 16'd127; tsv = 16'd64;  dv = 16'hFFFF;  end
                2: begin wsv = 16'd64;  tsv = 16'd127; dv = 16'd1;     end
                3: begin wsv = 16'd1;   tsv = 16'd1;   dv = 16'hFFFF;  end
                default: begin
                    wsv = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(1, 4))
                                                     : 16'($urandom_range(1, 64));
                    tsv = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(1, 4))
                                                     : 16'($urandom_range(1, 64));
                    r = $urandom_range(0, 9);
                    if (r < 4) dv = 16'($urandom_range(1, 1000));
                    else if (r < 6) dv = 16'd1;
                    else if (r < 8) dv = 16'($urandom_range(1, 65535));
                    else dv = 16'd440;
                    wsv = wsv | junk;
                    tsv = tsv | (junk ^ 16'hFF80);
                end
            endcase
            write_reg(REG_WEIGHT_SAMPLES, wsv);
            write_reg(REG_TARE_SAMPLES, tsv);
            write_reg(REG_SCALE_DIVISOR, dv);
            if (phase_no == 0) write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
            // every fourth phase runs both sides back to back
            gaps_on = (phase_no % 4) != 3;

            eff_d = (dv == 0) ? 1 : dv;
            base = $urandom_range(0, 24'h7FFFFF);
            unit = longint'($urandom_range(1, 300)) * eff_d;
            if (unit > 150000) unit = $urandom_range(1, 150000);
            nz = eff_d / 2;

            // well-formed opening: tare on the empty pan, then teach one piece
            send_item(CMD_TARE, 24'($urandom), 1'b0, no_reading);
            n_words = tsv[6:0];
            if (n_words == 0) n_words = 1;
            else if (n_words > MAX_AVERAGE) n_words = MAX_AVERAGE;
            repeat (n_words) send_item(CMD_SAMPLE, scale_word(base, unit, 0, nz), 1'b0, no_reading);
            send_item(CMD_REF, 24'($urandom), 1'b0, no_reading);
            n_words = wsv[6:0];
            if (n_words == 0) n_words = 1;
            else if (n_words > MAX_AVERAGE) n_words = MAX_AVERAGE;
            repeat (n_words) send_item(CMD_SAMPLE, scale_word(base, unit, 1, nz), 1'b0, no_reading);

            k = $urandom_range(0, 40);
            repeat (PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if ($urandom_range(0, 9) == 0) k = $urandom_range(0, 40);
                if (r < 1) wait_drained();
                if (r < 4) send_item(CMD_TARE, 24'($urandom), 1'b0, no_reading);
                else if (r < 8) send_item(CMD_REF, 24'($urandom), 1'b0, no_reading);
                else if (r < 10) send_item(CMD_UNUSED, 24'($urandom), 1'b0, no_reading);
                else if (r < 20) send_item(CMD_SAMPLE, 24'($urandom), 1'b0, no_reading);
                else send_item(CMD_SAMPLE, scale_word(base, unit, k, nz), 1'b0, no_reading);
            end
            phase_no++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("load_cell_piece_counter regression: pass");
        end else begin
            $display("load_cell_piece_counter regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("load_cell_piece_counter regression: fail");
        $finish;
    end

endmodule
